@@ src/chm_pkg.sv @@
`default_nettype none

package chm_pkg;

	localparam int DEF_MAX_BUCKETS = 256;
	localparam int DEF_MAX_ENTRIES = 1024;
	localparam int DEF_KEY_BITS    = 32;
	localparam int DEF_VALUE_BITS  = 32;

	localparam int CFG_W       = 9;
	localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 9'd251;
	localparam int HASH_SHIFT  = 2;
	localparam int DIV_RADIX   = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_LOOKUP = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	typedef enum logic [1:0] {
		CLS_NORMAL = 2'd0,
		CLS_ZERO   = 2'd1,
		CLS_IGNORE = 2'd2
	} cls_t;

	typedef struct packed {
		logic [1:0] req;
		cls_t       cls;
	} ctl_t;

endpackage

`default_nettype wire

@@ src/chm_front.sv @@
`default_nettype none

module chm_front #(
	parameter int MAX_BUCKETS = chm_pkg::DEF_MAX_BUCKETS,
	parameter int KEY_BITS    = chm_pkg::DEF_KEY_BITS,
	parameter int VALUE_BITS  = chm_pkg::DEF_VALUE_BITS,
	parameter int BKT_W       = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [1:0]                  req_type,
	input  wire logic [KEY_BITS-1:0]         key,
	input  wire logic [VALUE_BITS-1:0]       value,
	input  wire logic [chm_pkg::CFG_W-1:0]   bucket_count,
	input  wire logic                        q_full,
	output logic                             q_push,
	output chm_pkg::ctl_t                    q_ctl,
	output logic [KEY_BITS-1:0]              q_key,
	output logic [VALUE_BITS-1:0]            q_val,
	output logic [BKT_W-1:0]                 q_bkt
);
	import chm_pkg::*;

	localparam int NB_W  = $clog2(MAX_BUCKETS + 1);
	localparam int DIV_N = KEY_BITS - HASH_SHIFT;
	localparam int STEPS = (DIV_N + DIV_RADIX - 1) / DIV_RADIX;
	localparam int DW    = STEPS * DIV_RADIX;
	localparam int CW    = $clog2(STEPS + 1);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} fst_t;

	fst_t                  state_q;
	ctl_t                  ctl_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [NB_W-1:0]       n_q;
	logic [NB_W-1:0]       rem_q;
	logic [DW-1:0]         dq_q;
	logic [CW-1:0]         cnt_q;
	logic [NB_W-1:0]       rem_next;
	logic [NB_W-1:0]       n_eff;
	logic                  accept;
	cls_t                  cls_in;

	assign in_stall = (state_q != F_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		if (bucket_count == '0) begin
			n_eff = NB_W'(1);
		end else if (32'(bucket_count) > 32'(MAX_BUCKETS)) begin
			n_eff = NB_W'(MAX_BUCKETS);
		end else begin
			n_eff = NB_W'(bucket_count);
		end
	end

	always_comb begin
		if (req_type != REQ_INSERT && req_type != REQ_LOOKUP && req_type != REQ_DELETE) begin
			cls_in = CLS_IGNORE;
		end else if (key == '0) begin
			cls_in = CLS_ZERO;
		end else begin
			cls_in = CLS_NORMAL;
		end
	end

	// restoring remainder, DIV_RADIX dividend bits a cycle
	always_comb begin
		logic [NB_W:0]   t;
		logic [NB_W-1:0] r;
		r = rem_q;
		for (int i = 0; i < DIV_RADIX; i++) begin
			t = {r, dq_q[DW-1-i]};
			if (t >= {1'b0, n_q}) begin
				t = t - {1'b0, n_q};
			end
			r = t[NB_W-1:0];
		end
		rem_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= (cls_in == CLS_NORMAL) ? F_DIV : F_PUSH;
					end
				end
				F_DIV: begin
					if (cnt_q == '0) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_q.req <= req_type;
			ctl_q.cls <= cls_in;
			key_q     <= key;
			val_q     <= value;
			n_q       <= n_eff;
			rem_q     <= '0;
			dq_q      <= DW'(key >> HASH_SHIFT);
			cnt_q     <= CW'(STEPS - 1);
		end else if (state_q == F_DIV) begin
			rem_q <= rem_next;
			dq_q  <= dq_q << DIV_RADIX;
			cnt_q <= cnt_q - CW'(1);
		end
	end

	assign q_push = (state_q == F_PUSH) && !q_full;
	assign q_ctl  = ctl_q;
	assign q_key  = key_q;
	assign q_val  = val_q;
	assign q_bkt  = (ctl_q.cls == CLS_NORMAL) ? BKT_W'(rem_q) : '0;

endmodule

`default_nettype wire

@@ src/chm_queue.sv @@
`default_nettype none

module chm_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	input  wire logic         pop,
	output logic [W-1:0]      head_data,
	output logic              full,
	output logic              empty
);
	import chm_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]  mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [NW-1:0] cnt_q;

	assign full      = (cnt_q == NW'(QUEUE_DEPTH));
	assign empty     = (cnt_q == '0);
	assign head_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

@@ src/chm_back.sv @@
`default_nettype none

module chm_back #(
	parameter int MAX_BUCKETS = chm_pkg::DEF_MAX_BUCKETS,
	parameter int MAX_ENTRIES = chm_pkg::DEF_MAX_ENTRIES,
	parameter int KEY_BITS    = chm_pkg::DEF_KEY_BITS,
	parameter int VALUE_BITS  = chm_pkg::DEF_VALUE_BITS,
	parameter int BKT_W       = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
	parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_empty,
	output logic                       q_pop,
	input  wire chm_pkg::ctl_t         q_ctl,
	input  wire logic [KEY_BITS-1:0]   q_key,
	input  wire logic [VALUE_BITS-1:0] q_val,
	input  wire logic [BKT_W-1:0]      q_bkt,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       found,
	output logic [VALUE_BITS-1:0]      value_out,
	output logic [1:0]                 status,
	output logic [CNT_W-1:0]           entry_total
);
	import chm_pkg::*;

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int PTR_W = CNT_W;
	localparam logic [PTR_W-1:0] NIL = PTR_W'(MAX_ENTRIES);

	typedef enum logic [6:0] {
		B_IDLE   = 7'b0000001,
		B_HEAD   = 7'b0000010,
		B_WALK   = 7'b0000100,
		B_ACT    = 7'b0001000,
		B_RELINK = 7'b0010000,
		B_POP    = 7'b0100000,
		B_OUT    = 7'b1000000
	} bst_t;

	bst_t                  state_q;
	ctl_t                  ctl_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [BKT_W-1:0]      bkt_q;
	logic [PTR_W-1:0]      e_q, prev_q, head_q, nxt_q;
	logic                  found_q;
	logic [VALUE_BITS-1:0] vout_q;
	logic [1:0]            status_q;
	logic [CNT_W-1:0]      top_q, lw_q, count_q;

	// bucket heads, valid bit per bucket stands for the empty reset value
	logic [PTR_W-1:0]      heads_mem [MAX_BUCKETS];
	logic                  hvalid_q  [MAX_BUCKETS];
	logic [PTR_W-1:0]      hd_rd_q;
	logic                  hv_rd_q;

	logic [KEY_BITS-1:0]   key_mem  [MAX_ENTRIES];
	logic [VALUE_BITS-1:0] val_mem  [MAX_ENTRIES];
	logic [PTR_W-1:0]      link_mem [MAX_ENTRIES];
	logic [IDX_W-1:0]      stk_mem  [MAX_ENTRIES];
	logic [KEY_BITS-1:0]   ek_rd_q;
	logic [VALUE_BITS-1:0] ev_rd_q;
	logic [PTR_W-1:0]      el_rd_q;
	logic [IDX_W-1:0]      st_rd_q;

	logic [BKT_W-1:0]      head_ra;
	logic [PTR_W-1:0]      ev;
	logic [PTR_W-1:0]      ent_ra;
	logic [CNT_W-1:0]      top_m1;
	logic                  fresh;
	logic [PTR_W-1:0]      slot;
	logic                  out_valid_q;
	logic                  out_load;

	logic                  head_we;
	logic [PTR_W-1:0]      head_wd;
	logic                  key_we, val_we, link_we, stk_we;
	logic [PTR_W-1:0]      kv_wa, link_wa, link_wd;

	assign q_pop    = (state_q == B_IDLE) && !q_empty;
	assign head_ra  = (state_q == B_IDLE) ? q_bkt : bkt_q;
	assign ev       = hv_rd_q ? hd_rd_q : NIL;
	assign ent_ra   = (state_q == B_HEAD) ? ev : el_rd_q;
	assign top_m1   = top_q - CNT_W'(1);
	// a stack slot never popped before still holds its own index
	assign fresh    = (top_m1 < lw_q);
	assign slot     = fresh ? top_m1 : PTR_W'(st_rd_q);
	assign out_load = (state_q == B_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		head_we = 1'b0;
		head_wd = slot;
		key_we  = 1'b0;
		val_we  = 1'b0;
		link_we = 1'b0;
		stk_we  = 1'b0;
		kv_wa   = e_q;
		link_wa = prev_q;
		link_wd = nxt_q;
		case (state_q)
			B_ACT: begin
				if (found_q && (ctl_q.req == REQ_DELETE || ctl_q.req == REQ_INSERT)) begin
					stk_we = 1'b1;
					if (ctl_q.req == REQ_INSERT) begin
						val_we = 1'b1;
						if (prev_q != NIL) begin
							link_we = 1'b1;
							head_we = 1'b1;
							head_wd = e_q;
						end
					end else if (prev_q == NIL) begin
						head_we = 1'b1;
						head_wd = nxt_q;
					end else begin
						link_we = 1'b1;
					end
				end
			end
			B_RELINK: begin
				link_we = 1'b1;
				link_wa = e_q;
				link_wd = head_q;
			end
			B_POP: begin
				key_we  = 1'b1;
				val_we  = 1'b1;
				kv_wa   = slot;
				link_we = 1'b1;
				link_wa = slot;
				link_wd = head_q;
				head_we = 1'b1;
				head_wd = slot;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		hd_rd_q <= heads_mem[head_ra];
		if (head_we) begin
			heads_mem[bkt_q] <= head_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BUCKETS; i++) begin
				hvalid_q[i] <= 1'b0;
			end
			hv_rd_q <= 1'b0;
		end else begin
			hv_rd_q <= hvalid_q[head_ra];
			if (head_we) begin
				hvalid_q[bkt_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		ek_rd_q <= key_mem[ent_ra[IDX_W-1:0]];
		if (key_we) begin
			key_mem[kv_wa[IDX_W-1:0]] <= key_q;
		end
	end

	always_ff @(posedge clk) begin
		ev_rd_q <= val_mem[ent_ra[IDX_W-1:0]];
		if (val_we) begin
			val_mem[kv_wa[IDX_W-1:0]] <= val_q;
		end
	end

	always_ff @(posedge clk) begin
		el_rd_q <= link_mem[ent_ra[IDX_W-1:0]];
		if (link_we) begin
			link_mem[link_wa[IDX_W-1:0]] <= link_wd;
		end
	end

	always_ff @(posedge clk) begin
		st_rd_q <= stk_mem[top_m1[IDX_W-1:0]];
		if (stk_we) begin
			stk_mem[top_q[IDX_W-1:0]] <= e_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			top_q   <= CNT_W'(MAX_ENTRIES);
			lw_q    <= CNT_W'(MAX_ENTRIES);
			count_q <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						state_q <= (q_ctl.cls == CLS_NORMAL) ? B_HEAD : B_OUT;
					end
				end
				B_HEAD: begin
					state_q <= (ev == NIL) ? B_ACT : B_WALK;
				end
				B_WALK: begin
					if (ek_rd_q == key_q || el_rd_q == NIL) begin
						state_q <= B_ACT;
					end
				end
				B_ACT: begin
					state_q <= B_OUT;
					if (ctl_q.req == REQ_DELETE && found_q) begin
						top_q   <= top_q + CNT_W'(1);
						count_q <= count_q - CNT_W'(1);
					end else if (ctl_q.req == REQ_INSERT) begin
						if (found_q) begin
							if (prev_q != NIL) begin
								state_q <= B_RELINK;
							end
						end else if (top_q != '0) begin
							state_q <= B_POP;
						end
					end
				end
				B_RELINK: begin
					state_q <= B_OUT;
				end
				B_POP: begin
					top_q   <= top_m1;
					count_q <= count_q + CNT_W'(1);
					if (fresh) begin
						lw_q <= top_m1;
					end
					state_q <= B_OUT;
				end
				B_OUT: begin
					if (out_load) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				ctl_q    <= q_ctl;
				key_q    <= q_key;
				val_q    <= q_val;
				bkt_q    <= q_bkt;
				found_q  <= 1'b0;
				vout_q   <= '0;
				status_q <= (q_ctl.cls == CLS_ZERO) ? ST_ZERO : ST_OK;
			end
			B_HEAD: begin
				head_q <= ev;
				e_q    <= ev;
				prev_q <= NIL;
			end
			B_WALK: begin
				if (ek_rd_q == key_q) begin
					found_q <= 1'b1;
					vout_q  <= ev_rd_q;
					nxt_q   <= el_rd_q;
				end else if (el_rd_q == NIL) begin
					e_q <= NIL;
				end else begin
					prev_q <= e_q;
					e_q    <= el_rd_q;
				end
			end
			B_ACT: begin
				if (ctl_q.req == REQ_INSERT && !found_q && top_q == '0) begin
					status_q <= ST_FULL;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			found       <= found_q;
			value_out   <= vout_q;
			status      <= status_q;
			entry_total <= count_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ src/chained_hash_map_engine_core.sv @@
// path: a zero key or ignored type skips the remainder unit and the bucket walk; a normal request
//   passes the bucket remainder unit, the queue, the head read and one walk step per chain entry
//   visited, then the act step, with one more step for an insert that allocates or relinks
// pacing: the front takes no new request until it has pushed its current one into the queue, so
//   the 4-bit-a-cycle bucket remainder unit, or the back as it walks the chain, sets the pace
// reset: arst_n asynchronous active low; the bucket table is empty at once through
//   per-bucket valid bits, the free stack through a low-water mark; no clearing pass
`default_nettype none

module chained_hash_map_engine_core #(
	parameter int MAX_BUCKETS = chm_pkg::DEF_MAX_BUCKETS,
	parameter int MAX_ENTRIES = chm_pkg::DEF_MAX_ENTRIES,
	parameter int KEY_BITS    = chm_pkg::DEF_KEY_BITS,
	parameter int VALUE_BITS  = chm_pkg::DEF_VALUE_BITS,
	parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [chm_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [1:0]                req_type,
	input  wire logic [KEY_BITS-1:0]       key,
	input  wire logic [VALUE_BITS-1:0]     value,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic                           found,
	output logic [VALUE_BITS-1:0]          value_out,
	output logic [1:0]                     status,
	output logic [CNT_W-1:0]               entry_total
);
	import chm_pkg::*;

	localparam int BKT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int QW    = $bits(ctl_t) + KEY_BITS + VALUE_BITS + BKT_W;

	logic [CFG_W-1:0]      bucket_count_q;
	logic                  f_push, q_full, q_empty, q_pop;
	ctl_t                  f_ctl, b_ctl;
	logic [KEY_BITS-1:0]   f_key, b_key;
	logic [VALUE_BITS-1:0] f_val, b_val;
	logic [BKT_W-1:0]      f_bkt, b_bkt;
	logic [QW-1:0]         q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BUCKET_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bucket_count_q <= cfg_data;
		end
	end

	chm_front #(
		.MAX_BUCKETS(MAX_BUCKETS),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS),
		.BKT_W      (BKT_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.key         (key),
		.value       (value),
		.bucket_count(bucket_count_q),
		.q_full      (q_full),
		.q_push      (f_push),
		.q_ctl       (f_ctl),
		.q_key       (f_key),
		.q_val       (f_val),
		.q_bkt       (f_bkt)
	);

	chm_queue #(
		.W(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_push),
		.push_data({f_ctl, f_key, f_val, f_bkt}),
		.pop      (q_pop),
		.head_data(q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	assign {b_ctl, b_key, b_val, b_bkt} = q_head;

	chm_back #(
		.MAX_BUCKETS(MAX_BUCKETS),
		.MAX_ENTRIES(MAX_ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS),
		.BKT_W      (BKT_W),
		.CNT_W      (CNT_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.q_ctl      (b_ctl),
		.q_key      (b_key),
		.q_val      (b_val),
		.q_bkt      (b_bkt),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.value_out  (value_out),
		.status     (status),
		.entry_total(entry_total)
	);

endmodule

`default_nettype wire

@@ src/chm_checker.sv @@
`default_nettype none

module chm_checker #(
	parameter int MAX_ENTRIES = chm_pkg::DEF_MAX_ENTRIES,
	parameter int VALUE_BITS  = chm_pkg::DEF_VALUE_BITS,
	parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic                  found,
	input wire logic [VALUE_BITS-1:0] value_out,
	input wire logic [1:0]            status,
	input wire logic [CNT_W-1:0]      entry_total
);
	import chm_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value_out) && $stable(entry_total))
		else $error("result changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_FULL || status == ST_ZERO))
		else $error("bad status code");

	// zero-key or full requests report nothing found
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> !found && value_out == '0)
		else $error("found set on failed request");

	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> value_out == '0)
		else $error("value on miss");

	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(entry_total) <= 32'(MAX_ENTRIES))
		else $error("entry total above capacity");

endmodule

bind chained_hash_map_engine_core chm_checker #(
	.MAX_ENTRIES(MAX_ENTRIES),
	.VALUE_BITS (VALUE_BITS),
	.CNT_W      (CNT_W)
) u_chm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.found      (found),
	.value_out  (value_out),
	.status     (status),
	.entry_total(entry_total)
);

`default_nettype wire
